### hdl/cpt_pkg.sv
package cpt_pkg;

  // Coordinate width; the payload structs are fixed to it.
  localparam int CW    = 32;
  // Differences of coordinates.
  localparam int DW    = CW + 1;
  // Product of two differences.
  localparam int PW    = 2 * DW;
  // Cross product component.
  localparam int XW    = PW + 1;
  localparam int XLO   = (XW + 1) / 2;
  localparam int XHI   = XW - XLO;
  // Dot product of two cross products.
  localparam int DOTW  = 2 * XW + 2;
  // Edge dot product and squared edge length.
  localparam int LW    = PW + 2;
  localparam int LLO   = (LW + 1) / 2;
  localparam int LHI   = LW - LLO;
  // Interpolation numerator, divisor, quotient and division remainder.
  localparam int NW    = DW + LW + 2;
  localparam int DENW  = LW + 1;
  localparam int QW    = CW + 1;
  localparam int RW    = DENW + QW;
  // Edge point, its offset from the query point, square and distance.
  localparam int EW    = CW + 3;
  localparam int SDW   = EW + 1;
  localparam int SQW   = 2 * SDW;
  localparam int DSTW  = SQW + 2;

  // Partial product selectors.
  localparam int PP_HH = 0;
  localparam int PP_HL = 1;
  localparam int PP_LH = 2;
  localparam int PP_LL = 3;
  localparam int PD_HI = 0;
  localparam int PD_LO = 1;

  localparam logic signed [CW-1:0] CRD_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] CRD_MIN = {1'b1, {(CW-1){1'b0}}};

  typedef enum logic [1:0] {
    FEAT_INSIDE = 2'd0,
    FEAT_AB     = 2'd1,
    FEAT_BC     = 2'd2,
    FEAT_CA     = 2'd3
  } feat_t;

  typedef struct packed {
    logic signed [CW-1:0] vert_a_x;
    logic signed [CW-1:0] vert_a_y;
    logic signed [CW-1:0] vert_a_z;
    logic signed [CW-1:0] vert_b_x;
    logic signed [CW-1:0] vert_b_y;
    logic signed [CW-1:0] vert_b_z;
    logic signed [CW-1:0] vert_c_x;
    logic signed [CW-1:0] vert_c_y;
    logic signed [CW-1:0] vert_c_z;
    logic signed [CW-1:0] query_x;
    logic signed [CW-1:0] query_y;
    logic signed [CW-1:0] query_z;
  } in_item_t;

  typedef struct packed {
    logic signed [CW-1:0] near_x;
    logic signed [CW-1:0] near_y;
    logic signed [CW-1:0] near_z;
    logic [1:0]           source_feature;
    logic                 clipped;
  } out_item_t;

  // Per-item decisions gathered along the pipeline; neg is per edge and axis.
  typedef struct packed {
    logic       in_tri;
    logic [2:0] lo;
    logic [2:0] hi;
    logic [8:0] neg;
  } flg_t;

  // One shifted partial product of a cross-product component pair.
  function automatic logic signed [DOTW-1:0] xpart(input logic signed [XW-1:0] a,
                                                   input logic signed [XW-1:0] b,
                                                   input int sel);
    logic signed [XHI-1:0]     ah;
    logic signed [XHI-1:0]     bh;
    logic [XLO-1:0]            al;
    logic [XLO-1:0]            bl;
    logic signed [2*XHI-1:0]   phh;
    logic signed [XHI+XLO:0]   pmx;
    logic [2*XLO-1:0]          pll;
    logic signed [DOTW-1:0]    res;
    ah  = a[XW-1:XLO];
    bh  = b[XW-1:XLO];
    al  = a[XLO-1:0];
    bl  = b[XLO-1:0];
    phh = '0;
    pmx = '0;
    pll = '0;
    case (sel)
      PP_HH: begin
        phh = ah * bh;
        res = DOTW'(phh) <<< (2 * XLO);
      end
      PP_HL: begin
        pmx = ah * $signed({1'b0, bl});
        res = DOTW'(pmx) <<< XLO;
      end
      PP_LH: begin
        pmx = bh * $signed({1'b0, al});
        res = DOTW'(pmx) <<< XLO;
      end
      default: begin
        pll = al * bl;
        res = $signed(DOTW'(pll));
      end
    endcase
    return res;
  endfunction

  // One shifted partial product of edge vector times edge dot.
  function automatic logic signed [NW-1:0] dpart(input logic signed [DW-1:0] ab,
                                                 input logic signed [LW-1:0] d,
                                                 input int sel);
    logic signed [LHI-1:0]      dh;
    logic [LLO-1:0]             dl;
    logic signed [DW+LHI-1:0]   phi;
    logic signed [DW+LLO:0]     plo;
    logic signed [NW-1:0]       res;
    dh  = d[LW-1:LLO];
    dl  = d[LLO-1:0];
    phi = '0;
    plo = '0;
    case (sel)
      PD_HI: begin
        phi = ab * dh;
        res = NW'(phi) <<< LLO;
      end
      default: begin
        plo = ab * $signed({1'b0, dl});
        res = NW'(plo);
      end
    endcase
    return res;
  endfunction

  function automatic logic [SQW-1:0] sqr(input logic signed [SDW-1:0] v);
    logic signed [SQW-1:0] p;
    p = v * v;
    return $unsigned(p);
  endfunction

endpackage

### hdl/cpt_div.sv
module cpt_div #(
  parameter int RW_P   = cpt_pkg::RW,
  parameter int DENW_P = cpt_pkg::DENW,
  parameter int QW_P   = cpt_pkg::QW
) (
  input  logic              clk,
  input  logic              en,
  input  logic [RW_P-1:0]   num_i,
  input  logic [DENW_P-1:0] den_i,
  output logic [QW_P-1:0]   quo_o,
  output logic              rem_nz_o
);

  // Restoring division, one quotient bit per stage, most significant first.
  logic [RW_P-1:0]   part_r   [QW_P];
  logic [RW_P-1:0]   part_nxt [QW_P];
  logic [DENW_P-1:0] dvs_r    [QW_P];
  logic [QW_P-1:0]   quo_r    [QW_P];
  logic [QW_P-1:0]   quo_nxt  [QW_P];

  always_comb begin
    logic [RW_P-1:0] cur;
    logic [RW_P-1:0] shd;
    logic [RW_P:0]   dif;
    logic [QW_P-1:0] qin;
    for (int j = 0; j < QW_P; j++) begin
      cur = (j == 0) ? num_i : part_r[(j == 0) ? 0 : j-1];
      qin = (j == 0) ? '0 : quo_r[(j == 0) ? 0 : j-1];
      shd = (j == 0) ? (RW_P'(den_i) << (QW_P-1-j))
                     : (RW_P'(dvs_r[(j == 0) ? 0 : j-1]) << (QW_P-1-j));
      dif = {1'b0, cur} - {1'b0, shd};
      part_nxt[j] = dif[RW_P] ? cur : dif[RW_P-1:0];
      quo_nxt[j]  = {qin[QW_P-2:0], ~dif[RW_P]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < QW_P; j++) begin
        part_r[j] <= part_nxt[j];
        quo_r[j]  <= quo_nxt[j];
        dvs_r[j]  <= (j == 0) ? den_i : dvs_r[(j == 0) ? 0 : j-1];
      end
    end
  end

  assign quo_o    = quo_r[QW_P-1];
  assign rem_nz_o = |part_r[QW_P-1];

endmodule

### hdl/closest_point_on_triangle.sv
// Channel   Direction  Handshake             Payload
// in_       input      in_valid / in_ready   cpt_pkg::in_item_t  (triangle A, B, C, query P)
// out_      output     out_valid / out_ready cpt_pkg::out_item_t (nearest point, feature, clip)
//
// One item accepted per cycle while in_ready is high. Most of the pipeline is the
// 33-stage bit-per-stage divider that interpolates the edge points.
// Reset (rst_n low, synchronous) empties every stage, the output register and the skid.
// On an output stall the finished result parks in a skid register; in_ready falls only
// once that skid holds an item, and the whole pipeline then holds until it drains.
module closest_point_on_triangle (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  cpt_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output cpt_pkg::out_item_t out_data
);
  import cpt_pkg::*;

  // Stage indices: 0 differences, 1 products, 2 sums, 3 wide partials,
  // 4 wide sums, 5 numerator and inside test, 6 magnitude (divider feed),
  // then the divider, edge point, squared offsets and distances.
  localparam int KD = 6;
  localparam int KQ = KD + QW;
  localparam int KE = KQ + 1;
  localparam int NS = KE + 3;

  logic          en;
  logic [NS-1:0] vld_r;

  logic signed [CW-1:0] in_crd [12];
  logic signed [CW-1:0] crd_r  [NS][12];
  flg_t                 flg_r  [NS];
  flg_t                 flg_nxt[NS];

  logic signed [DW-1:0]   ab0_nxt [3][3];
  logic signed [DW-1:0]   ap0_nxt [3][3];
  logic signed [DW-1:0]   ab0_r   [3][3];
  logic signed [DW-1:0]   ap0_r   [3][3];
  logic signed [DW-1:0]   ab1_r   [3][3];
  logic signed [DW-1:0]   ab2_r   [3][3];
  logic signed [PW-1:0]   xp_nxt  [3][3][2];
  logic signed [PW-1:0]   xp_r    [3][3][2];
  logic signed [PW-1:0]   dp_nxt  [3][3];
  logic signed [PW-1:0]   dp_r    [3][3];
  logic signed [PW-1:0]   lp_nxt  [3][3];
  logic signed [PW-1:0]   lp_r    [3][3];
  logic signed [XW-1:0]   x_nxt   [3][3];
  logic signed [XW-1:0]   x_r     [3][3];
  logic signed [LW-1:0]   d_nxt   [3];
  logic signed [LW-1:0]   d_r     [3];
  logic signed [LW-1:0]   l2_nxt  [3];
  logic signed [LW-1:0]   l2_r    [3];
  logic signed [LW-1:0]   l3_r    [3];
  logic signed [LW-1:0]   l4_r    [3];
  logic signed [LW-1:0]   l5_r    [3];
  logic signed [DOTW-1:0] cpp_nxt [2][3][4];
  logic signed [DOTW-1:0] cpp_r   [2][3][4];
  logic signed [NW-1:0]   app_nxt [3][3][2];
  logic signed [NW-1:0]   app_r   [3][3][2];
  logic signed [DOTW-1:0] cp_nxt  [2][3];
  logic signed [DOTW-1:0] cp_r    [2][3];
  logic signed [NW-1:0]   ad_nxt  [3][3];
  logic signed [NW-1:0]   ad_r    [3][3];
  logic signed [NW-1:0]   num_nxt [3][3];
  logic signed [NW-1:0]   num_r   [3][3];
  logic [RW-1:0]          mag_nxt [3][3];
  logic [RW-1:0]          mag_r   [3][3];
  logic [DENW-1:0]        den_r   [3];
  logic [QW-1:0]          quo     [3][3];
  logic                   rnz     [3][3];
  logic signed [EW-1:0]   e_nxt   [3][3];
  logic signed [EW-1:0]   e_r     [3][3];
  logic signed [EW-1:0]   e1_r    [3][3];
  logic signed [EW-1:0]   e2_r    [3][3];
  logic [SQW-1:0]         sq_nxt  [3][3];
  logic [SQW-1:0]         sq_r    [3][3];
  logic [DSTW-1:0]        dist_nxt[3];
  logic [DSTW-1:0]        dist_r  [3];

  out_item_t res_nxt;
  out_item_t out_r;
  out_item_t skid_r;
  logic      out_vld_r, out_vld_nxt;
  logic      skid_vld_r, skid_vld_nxt;
  logic      push, pop, out_ld, out_from_skid, skid_ld;

  // Advance everything while the skid is free; the skid absorbs the one item
  // that may leave the last stage while the output register is still full.
  assign en       = ~skid_vld_r;
  assign in_ready = en;

  assign in_crd[0]  = in_data.vert_a_x;
  assign in_crd[1]  = in_data.vert_a_y;
  assign in_crd[2]  = in_data.vert_a_z;
  assign in_crd[3]  = in_data.vert_b_x;
  assign in_crd[4]  = in_data.vert_b_y;
  assign in_crd[5]  = in_data.vert_b_z;
  assign in_crd[6]  = in_data.vert_c_x;
  assign in_crd[7]  = in_data.vert_c_y;
  assign in_crd[8]  = in_data.vert_c_z;
  assign in_crd[9]  = in_data.query_x;
  assign in_crd[10] = in_data.query_y;
  assign in_crd[11] = in_data.query_z;

  // Stage 0: edge vectors E-S and offsets P-S, edge e runs from vertex e to vertex e+1.
  always_comb begin
    for (int e = 0; e < 3; e++) begin
      for (int m = 0; m < 3; m++) begin
        ab0_nxt[e][m] = DW'(in_crd[((e + 1) % 3) * 3 + m]) - DW'(in_crd[e * 3 + m]);
        ap0_nxt[e][m] = DW'(in_crd[9 + m]) - DW'(in_crd[e * 3 + m]);
      end
    end
  end

  // Stage 1: cross-product terms, edge dot terms and squared-length terms. The inside
  // test's crosses (A-P)x(B-P) etc. equal (P-A)x(P-B) etc., so reuse the offsets.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      for (int m = 0; m < 3; m++) begin
        xp_nxt[c][m][0] = ap0_r[c][(m + 1) % 3] * ap0_r[(c + 1) % 3][(m + 2) % 3];
        xp_nxt[c][m][1] = ap0_r[c][(m + 2) % 3] * ap0_r[(c + 1) % 3][(m + 1) % 3];
        dp_nxt[c][m]    = ap0_r[c][m] * ab0_r[c][m];
        lp_nxt[c][m]    = ab0_r[c][m] * ab0_r[c][m];
      end
    end
  end

  // Stage 2: cross components, edge dot and squared length.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      for (int m = 0; m < 3; m++) begin
        x_nxt[c][m] = XW'(xp_r[c][m][0]) - XW'(xp_r[c][m][1]);
      end
      d_nxt[c]  = LW'(dp_r[c][0]) + LW'(dp_r[c][1]) + LW'(dp_r[c][2]);
      l2_nxt[c] = LW'(lp_r[c][0]) + LW'(lp_r[c][1]) + LW'(lp_r[c][2]);
    end
  end

  // Stage 3: split the wide products into partial products of halves of at most 34 bits.
  always_comb begin
    for (int j = 0; j < 2; j++) begin
      for (int m = 0; m < 3; m++) begin
        for (int s = 0; s < 4; s++) begin
          cpp_nxt[j][m][s] = xpart(x_r[0][m], x_r[j + 1][m], s);
        end
      end
    end
    for (int e = 0; e < 3; e++) begin
      for (int m = 0; m < 3; m++) begin
        app_nxt[e][m][PD_HI] = dpart(ab2_r[e][m], d_r[e], PD_HI);
        app_nxt[e][m][PD_LO] = dpart(ab2_r[e][m], d_r[e], PD_LO);
      end
    end
  end

  // Stage 4: gather the partials.
  always_comb begin
    for (int j = 0; j < 2; j++) begin
      for (int m = 0; m < 3; m++) begin
        cp_nxt[j][m] = cpp_r[j][m][PP_HH] + cpp_r[j][m][PP_HL]
                     + cpp_r[j][m][PP_LH] + cpp_r[j][m][PP_LL];
      end
    end
    for (int e = 0; e < 3; e++) begin
      for (int m = 0; m < 3; m++) begin
        ad_nxt[e][m] = app_r[e][m][PD_HI] + app_r[e][m][PD_LO];
      end
    end
  end

  // Stage 5: numerator 2*ab*d + L for rounding to nearest, ties upward.
  // Stage 6: magnitude for the unsigned divider, sign kept for the floor.
  always_comb begin
    logic signed [NW-1:0] t;
    for (int e = 0; e < 3; e++) begin
      for (int m = 0; m < 3; m++) begin
        num_nxt[e][m] = (ad_r[e][m] <<< 1) + NW'(l4_r[e]);
        t             = num_r[e][m][NW-1] ? -num_r[e][m] : num_r[e][m];
        mag_nxt[e][m] = t[RW-1:0];
      end
    end
  end

  // Decisions: clamp flags at stage 3, inside test at 5, numerator sign at 6.
  always_comb begin
    logic signed [DOTW-1:0] dot0;
    logic signed [DOTW-1:0] dot1;
    for (int k = 0; k < NS; k++) begin
      flg_nxt[k] = (k == 0) ? '0 : flg_r[(k == 0) ? 0 : k-1];
    end
    for (int e = 0; e < 3; e++) begin
      flg_nxt[3].lo[e]  = d_r[e][LW-1] | (d_r[e] == '0);
      flg_nxt[3].hi[e]  = (d_r[e] >= l2_r[e]);
      for (int m = 0; m < 3; m++) begin
        flg_nxt[KD].neg[e * 3 + m] = num_r[e][m][NW-1];
      end
    end
    dot0 = cp_r[0][0] + cp_r[0][1] + cp_r[0][2];
    dot1 = cp_r[1][0] + cp_r[1][1] + cp_r[1][2];
    flg_nxt[5].in_tri = ~dot0[DOTW-1] & ~dot1[DOTW-1];
  end

  // Divider lanes, one per edge and axis.
  for (genvar ge = 0; ge < 3; ge++) begin : g_edge
    for (genvar gm = 0; gm < 3; gm++) begin : g_axis
      cpt_div #(
        .RW_P   (RW),
        .DENW_P (DENW),
        .QW_P   (QW)
      ) u_div (
        .clk      (clk),
        .en       (en),
        .num_i    (mag_r[ge][gm]),
        .den_i    (den_r[ge]),
        .quo_o    (quo[ge][gm]),
        .rem_nz_o (rnz[ge][gm])
      );
    end
  end

  // Edge point: start if d <= 0, end if d >= L, else start + floor quotient.
  always_comb begin
    logic signed [EW-1:0] qx;
    logic signed [EW-1:0] qs;
    for (int e = 0; e < 3; e++) begin
      for (int m = 0; m < 3; m++) begin
        qx = $signed(EW'(quo[e][m]));
        if (flg_r[KQ].neg[e * 3 + m]) begin
          qs = rnz[e][m] ? (-qx - EW'(1)) : -qx;
        end else begin
          qs = qx;
        end
        if (flg_r[KQ].lo[e]) begin
          e_nxt[e][m] = EW'(crd_r[KQ][e * 3 + m]);
        end else if (flg_r[KQ].hi[e]) begin
          e_nxt[e][m] = EW'(crd_r[KQ][((e + 1) % 3) * 3 + m]);
        end else begin
          e_nxt[e][m] = EW'(crd_r[KQ][e * 3 + m]) + qs;
        end
      end
    end
  end

  // Squared offsets from P, then the three squared distances.
  always_comb begin
    for (int e = 0; e < 3; e++) begin
      for (int m = 0; m < 3; m++) begin
        sq_nxt[e][m] = sqr(SDW'(crd_r[KE][9 + m]) - SDW'(e_r[e][m]));
      end
      dist_nxt[e] = DSTW'(sq_r[e][0]) + DSTW'(sq_r[e][1]) + DSTW'(sq_r[e][2]);
    end
  end

  // Pick the winner (ties fall to edge C-A), then saturate.
  always_comb begin
    logic signed [EW-1:0] sel [3];
    logic                 clip;
    feat_t                feat;
    clip = 1'b0;
    if (flg_r[NS-1].in_tri) begin
      feat = FEAT_INSIDE;
      for (int m = 0; m < 3; m++) sel[m] = EW'(crd_r[NS-1][9 + m]);
    end else if (dist_r[0] < dist_r[1] && dist_r[0] < dist_r[2]) begin
      feat = FEAT_AB;
      for (int m = 0; m < 3; m++) sel[m] = e2_r[0][m];
    end else if (dist_r[1] < dist_r[0] && dist_r[1] < dist_r[2]) begin
      feat = FEAT_BC;
      for (int m = 0; m < 3; m++) sel[m] = e2_r[1][m];
    end else begin
      feat = FEAT_CA;
      for (int m = 0; m < 3; m++) sel[m] = e2_r[2][m];
    end
    for (int m = 0; m < 3; m++) begin
      if (sel[m] > EW'(CRD_MAX)) begin
        sel[m] = EW'(CRD_MAX);
        clip   = 1'b1;
      end else if (sel[m] < EW'(CRD_MIN)) begin
        sel[m] = EW'(CRD_MIN);
        clip   = 1'b1;
      end
    end
    res_nxt.near_x         = sel[0][CW-1:0];
    res_nxt.near_y         = sel[1][CW-1:0];
    res_nxt.near_z         = sel[2][CW-1:0];
    res_nxt.source_feature = feat;
    res_nxt.clipped        = clip;
  end

  // Output register and skid: drain the skid first, keep order.
  always_comb begin
    push          = en & vld_r[NS-1];
    pop           = out_vld_r & out_ready;
    out_ld        = 1'b0;
    out_from_skid = 1'b0;
    skid_ld       = 1'b0;
    out_vld_nxt   = out_vld_r;
    skid_vld_nxt  = skid_vld_r;
    if (pop) begin
      if (skid_vld_r) begin
        out_ld        = 1'b1;
        out_from_skid = 1'b1;
        skid_vld_nxt  = 1'b0;
      end else if (push) begin
        out_ld = 1'b1;
      end else begin
        out_vld_nxt = 1'b0;
      end
    end else if (push) begin
      if (out_vld_r) begin
        skid_ld      = 1'b1;
        skid_vld_nxt = 1'b1;
      end else begin
        out_ld      = 1'b1;
        out_vld_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r      <= '0;
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      if (en) begin
        vld_r <= {vld_r[NS-2:0], in_valid};
      end
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  // Payload: advance all stages together; hold on a stall.
  always_ff @(posedge clk) begin
    if (en) begin
      crd_r[0] <= in_crd;
      for (int k = 1; k < NS; k++) crd_r[k] <= crd_r[k-1];
      for (int k = 0; k < NS; k++) flg_r[k] <= flg_nxt[k];
      ab0_r   <= ab0_nxt;
      ap0_r   <= ap0_nxt;
      ab1_r   <= ab0_r;
      ab2_r   <= ab1_r;
      xp_r    <= xp_nxt;
      dp_r    <= dp_nxt;
      lp_r    <= lp_nxt;
      x_r     <= x_nxt;
      d_r     <= d_nxt;
      l2_r    <= l2_nxt;
      l3_r    <= l2_r;
      l4_r    <= l3_r;
      l5_r    <= l4_r;
      cpp_r   <= cpp_nxt;
      app_r   <= app_nxt;
      cp_r    <= cp_nxt;
      ad_r    <= ad_nxt;
      num_r   <= num_nxt;
      mag_r   <= mag_nxt;
      for (int e = 0; e < 3; e++) den_r[e] <= {l5_r[e][LW-1:0], 1'b0};
      e_r     <= e_nxt;
      e1_r    <= e_r;
      e2_r    <= e1_r;
      sq_r    <= sq_nxt;
      dist_r  <= dist_nxt;
    end
    if (out_ld) begin
      out_r <= out_from_skid ? skid_r : res_nxt;
    end
    if (skid_ld) begin
      skid_r <= res_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

### hdl/cpt_chk.sv
module cpt_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input cpt_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input cpt_pkg::out_item_t out_data
);
  import cpt_pkg::*;

  // Edge points lie between their ends, so nothing ever saturates.
  a_no_clip: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !out_data.clipped)
    else $error("result item saturated");

  // Input back-pressure only follows an output stall.
  a_ready_fall: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_ready) |-> $past(out_valid && !out_ready))
    else $error("in_ready dropped without an output stall");

  // Reset empties the output.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result item shown after reset");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result item changed or dropped");

endmodule

bind closest_point_on_triangle cpt_chk u_cpt_chk (.*);
